FILE: sv/shs_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
`default_nettype none
package shs_pkg;

	// request coming in: one message byte or a finish
	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} req_t;

	// result going out: digest and pin compare
	typedef struct packed {
		logic [63:0] digest_high;
		logic [63:0] digest_upper_mid;
		logic [63:0] digest_lower_mid;
		logic [63:0] digest_low;
		logic        pin_match;
	} res_t;

	// word queue entry between front and back
	typedef struct packed {
		logic [31:0] word;
		logic        last;      // word 15 of the final block of a message
		logic        nonempty;  // message had at least one byte (valid with last)
	} qent_t;

	localparam logic ACT_ABSORB = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	localparam int          CFG_IDX_W          = 3;
	localparam logic [2:0]  CFG_PIN_HIGH       = 3'd0;
	localparam logic [2:0]  CFG_PIN_UPPER_MID  = 3'd1;
	localparam logic [2:0]  CFG_PIN_LOWER_MID  = 3'd2;
	localparam logic [2:0]  CFG_PIN_LOW        = 3'd3;

	localparam logic [7:0]  PAD_BYTE     = 8'h80;
	localparam logic [3:0]  LEN_WORD_HI  = 4'd14;
	localparam logic [3:0]  LEN_WORD_LO  = 4'd15;
	localparam logic [5:0]  LAST_LOAD_RND = 6'd15;
	localparam logic [5:0]  LAST_RND      = 6'd63;

	localparam logic [31:0] H_INIT [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_TAB [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] sml_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] sml_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage
`default_nettype wire

FILE: sv/sha256_stream_hasher_unit.sv
// Intake: a byte request is taken while the word queue has room; each 64-byte block runs
//   16 rounds fed as words arrive, 48 expanded rounds, then an add into the chaining words.
// Steady stream: the four-word queue fills during the 48 expanded rounds and the add, then
//   the 16 load rounds wait on one word per four bytes.
// Finish: the pad sequencer emits one word a cycle while the queue has room (one or two
//   blocks); res_valid rises after the last block's final round, the add and the emit
//   into the output register; no requests are taken while padding.
// Reset: chaining words to the initial hash, counters and pinned digest to zero, no sweep.
`default_nettype none
module sha256_stream_hasher_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	output logic                                  req_stall,
	input  wire shs_pkg::req_t                    req_data,
	output logic                                  res_valid,
	input  wire logic                             res_stall,
	output shs_pkg::res_t                         res_data,
	input  wire logic                             cfg_we,
	input  wire logic [shs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [63:0]                      cfg_wdata
);

	// pinned digest, four 64-bit words, high word first
	logic [63:0] pin_q [4];

	logic           q_push;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;
	shs_pkg::qent_t q_ent_in;
	shs_pkg::qent_t q_ent_out;

	logic [255:0] dig;
	logic         dig_ne;

	// configuration writes; indexes past the pin words are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				pin_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				shs_pkg::CFG_PIN_HIGH:      pin_q[0] <= cfg_wdata;
				shs_pkg::CFG_PIN_UPPER_MID: pin_q[1] <= cfg_wdata;
				shs_pkg::CFG_PIN_LOWER_MID: pin_q[2] <= cfg_wdata;
				shs_pkg::CFG_PIN_LOW:       pin_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front: byte packing, length count, padding words
	shs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.q_push    (q_push),
		.q_ent     (q_ent_in),
		.q_full    (q_full)
	);

	// decouples byte intake from the round engine
	shs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.ent_in  (q_ent_in),
		.full    (q_full),
		.valid   (q_valid),
		.ent_out (q_ent_out),
		.pop     (q_pop)
	);

	// back: compression rounds, chaining words, registered digest
	shs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ent     (q_ent_out),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.digest    (dig),
		.nonempty  (dig_ne)
	);

	// pins only change while idle, so the compare on the held digest is stable; the block does not enforce it
	always_comb begin
		res_data.digest_high      = dig[255:192];
		res_data.digest_upper_mid = dig[191:128];
		res_data.digest_lower_mid = dig[127:64];
		res_data.digest_low       = dig[63:0];
		res_data.pin_match        = dig_ne &&
			(dig == {pin_q[0], pin_q[1], pin_q[2], pin_q[3]});
	end

endmodule
`default_nettype wire

FILE: sv/shs_queue.sv
// Small word queue between the byte front end and the round engine.
`default_nettype none
module shs_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire shs_pkg::qent_t ent_in,
	output logic               full,
	output logic               valid,
	output shs_pkg::qent_t     ent_out,
	input  wire logic          pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	shs_pkg::qent_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_FULL);
	assign valid   = (cnt_q != '0);
	assign ent_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= ent_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && valid) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push && !full, pop && valid})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/shs_front.sv
// Front end: packs bytes into big-endian words, counts length, runs padding.
`default_nettype none
module shs_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire shs_pkg::req_t req_data,
	output logic               q_push,
	output shs_pkg::qent_t     q_ent,
	input  wire logic          q_full
);

	logic [5:0]  fill_q;      // bytes in the partial block
	logic [23:0] acc_q;       // up to three bytes of the partial word
	logic [60:0] bytes_q;     // message length in bytes, wraps with the bit length
	logic        busy_q;      // padding sequencer running
	logic        first_q;     // next pad word carries the 0x80 byte
	logic        final_q;     // current pad block holds the length
	logic [3:0]  widx_q;      // word index in the block being padded
	logic [63:0] len_q;
	logic [31:0] pad_q;
	logic        nonempty_q;

	logic        accept;
	logic [31:0] pad_word;

	assign req_stall = busy_q || q_full;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		unique case (fill_q[1:0])
			2'd0:    pad_word = {shs_pkg::PAD_BYTE, 24'h0};
			2'd1:    pad_word = {acc_q[7:0], shs_pkg::PAD_BYTE, 16'h0};
			2'd2:    pad_word = {acc_q[15:0], shs_pkg::PAD_BYTE, 8'h0};
			default: pad_word = {acc_q[23:0], shs_pkg::PAD_BYTE};
		endcase
	end

	always_comb begin
		q_ent.nonempty = nonempty_q;
		if (busy_q) begin
			q_push     = !q_full;
			q_ent.last = final_q && (widx_q == shs_pkg::LEN_WORD_LO);
			if (first_q) begin
				q_ent.word = pad_q;
			end else if (final_q && widx_q == shs_pkg::LEN_WORD_HI) begin
				q_ent.word = len_q[63:32];
			end else if (final_q && widx_q == shs_pkg::LEN_WORD_LO) begin
				q_ent.word = len_q[31:0];
			end else begin
				q_ent.word = 32'h0;
			end
		end else begin
			q_push     = accept && (req_data.action == shs_pkg::ACT_ABSORB) &&
				(fill_q[1:0] == 2'b11);
			q_ent.last = 1'b0;
			q_ent.word = {acc_q, req_data.data_byte};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req_data.action == shs_pkg::ACT_ABSORB) begin
				acc_q <= {acc_q[15:0], req_data.data_byte};
			end else begin
				len_q      <= {bytes_q, 3'b000};
				nonempty_q <= (bytes_q != '0);
				pad_q      <= pad_word;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			bytes_q <= '0;
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			final_q <= 1'b0;
			widx_q  <= '0;
		end else if (accept) begin
			if (req_data.action == shs_pkg::ACT_ABSORB) begin
				fill_q  <= fill_q + 1'b1;
				bytes_q <= bytes_q + 1'b1;
			end else begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				widx_q  <= fill_q[5:2];
				// 56 or more bytes: length goes into an extra block
				final_q <= (fill_q[5:3] != 3'b111);
				fill_q  <= '0;
				bytes_q <= '0;
			end
		end else if (busy_q && !q_full) begin
			first_q <= 1'b0;
			widx_q  <= widx_q + 1'b1;
			if (widx_q == shs_pkg::LEN_WORD_LO) begin
				if (final_q) begin
					busy_q <= 1'b0;
				end else begin
					final_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/shs_back.sv
// Back end: one SHA-256 round per cycle (load rounds wait for queued words), chaining words and digest register.
`default_nettype none
module shs_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire shs_pkg::qent_t q_ent,
	output logic                q_pop,
	output logic                res_valid,
	input  wire logic           res_stall,
	output logic [255:0]        digest,
	output logic                nonempty
);

	localparam logic [1:0] ST_LOAD = 2'd0;  // rounds 0..15, words from queue
	localparam logic [1:0] ST_EXP  = 2'd1;  // rounds 16..63, expanded schedule
	localparam logic [1:0] ST_ADD  = 2'd2;  // fold into chaining words
	localparam logic [1:0] ST_EMIT = 2'd3;  // hand digest to output register

	logic [1:0]  st_q;
	logic [5:0]  rnd_q;
	logic [31:0] h_q  [8];
	logic [31:0] wk_q [8];
	logic [31:0] w_q  [16];
	logic        last_q;
	logic        ne_q;
	logic        out_valid_q;
	logic [255:0] out_dig_q;
	logic        out_ne_q;

	logic        do_round;
	logic        emit_ok;
	logic [31:0] w_sched;
	logic [31:0] w_cur;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] mj;
	logic [31:0] sum [8];

	assign q_pop     = (st_q == ST_LOAD) && q_valid;
	assign do_round  = q_pop || (st_q == ST_EXP);
	assign emit_ok   = !out_valid_q || !res_stall;
	assign res_valid = out_valid_q;
	assign digest    = out_dig_q;
	assign nonempty  = out_ne_q;

	always_comb begin
		w_sched = w_q[0] + shs_pkg::sml_sig0(w_q[1]) + w_q[9] + shs_pkg::sml_sig1(w_q[14]);
		w_cur   = (st_q == ST_LOAD) ? q_ent.word : w_sched;
		ch      = (wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]);
		mj      = (wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]);
		t1      = wk_q[7] + shs_pkg::big_sig1(wk_q[4]) + ch + shs_pkg::K_TAB[rnd_q] + w_cur;
		t2      = shs_pkg::big_sig0(wk_q[0]) + mj;
		for (int i = 0; i < 8; i++) begin
			sum[i] = h_q[i] + wk_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (do_round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_cur;
		end
		if (st_q == ST_EMIT && emit_ok) begin
			out_dig_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
			out_ne_q  <= ne_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_LOAD;
			rnd_q       <= '0;
			last_q      <= 1'b0;
			ne_q        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i]  <= shs_pkg::H_INIT[i];
				wk_q[i] <= shs_pkg::H_INIT[i];
			end
		end else begin
			out_valid_q <= (st_q == ST_EMIT && emit_ok) || (out_valid_q && res_stall);
			if (do_round) begin
				wk_q[0] <= t1 + t2;
				wk_q[1] <= wk_q[0];
				wk_q[2] <= wk_q[1];
				wk_q[3] <= wk_q[2];
				wk_q[4] <= wk_q[3] + t1;
				wk_q[5] <= wk_q[4];
				wk_q[6] <= wk_q[5];
				wk_q[7] <= wk_q[6];
				rnd_q   <= rnd_q + 1'b1;
			end
			unique case (st_q)
				ST_LOAD: begin
					if (q_valid && rnd_q == shs_pkg::LAST_LOAD_RND) begin
						last_q <= q_ent.last;
						ne_q   <= q_ent.nonempty;
						st_q   <= ST_EXP;
					end
				end
				ST_EXP: begin
					if (rnd_q == shs_pkg::LAST_RND) begin
						st_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i]  <= sum[i];
						wk_q[i] <= sum[i];
					end
					st_q <= last_q ? ST_EMIT : ST_LOAD;
				end
				ST_EMIT: begin
					if (emit_ok) begin
						for (int i = 0; i < 8; i++) begin
							h_q[i]  <= shs_pkg::H_INIT[i];
							wk_q[i] <= shs_pkg::H_INIT[i];
						end
						st_q <= ST_LOAD;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sim/tb_sha256_stream_hasher_unit.sv
// Self-checking testbench for the SHA-256 stream hasher: byte and finish requests, pinned digest.
module tb_sha256_stream_hasher_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import shs_pkg::*;

	// hold-off length for the back-pressure phase, quiet time after a drain, hang limit
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 160;   // time for two padded blocks, plus margin
	localparam int WATCHDOG_LIMIT = 20000;

	// first register index past the pinned digest; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_PIN_LOW + 1'b1;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] SHA_IV [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// well-known digests: empty message and "abc"; pins are zero when these run
	localparam res_t EMPTY_DIGEST = {
		256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855, 1'b0};
	localparam res_t ABC_DIGEST = {
		256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad, 1'b0};

	// directed stimulus: a request repeated reps times, data byte counting up per repeat
	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic [7:0] reps;
		logic       typed;     // want holds the digest; otherwise the predictor decides
		res_t       want;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [0:18] = '{
		'{ACT_FINISH, 8'hff, 8'd1,   1'b1, EMPTY_DIGEST},  // empty message right after reset
		'{ACT_ABSORB, 8'h61, 8'd1,   1'b0, '0},
		'{ACT_ABSORB, 8'h62, 8'd1,   1'b0, '0},
		'{ACT_ABSORB, 8'h63, 8'd1,   1'b0, '0},
		'{ACT_FINISH, 8'h00, 8'd1,   1'b1, ABC_DIGEST},
		'{ACT_ABSORB, 8'h00, 8'd1,   1'b0, '0},            // byte extremes
		'{ACT_ABSORB, 8'hff, 8'd1,   1'b0, '0},
		'{ACT_FINISH, 8'h5a, 8'd1,   1'b0, '0},
		'{ACT_ABSORB, 8'h10, 8'd55,  1'b0, '0},            // padding just fits
		'{ACT_FINISH, 8'hff, 8'd1,   1'b0, '0},
		'{ACT_ABSORB, 8'h20, 8'd56,  1'b0, '0},            // length spills into an extra block
		'{ACT_FINISH, 8'h01, 8'd1,   1'b0, '0},
		'{ACT_ABSORB, 8'h30, 8'd63,  1'b0, '0},            // marker byte ends the block
		'{ACT_FINISH, 8'h80, 8'd1,   1'b0, '0},
		'{ACT_ABSORB, 8'h40, 8'd64,  1'b0, '0},            // exactly one full block
		'{ACT_FINISH, 8'h7f, 8'd1,   1'b0, '0},
		'{ACT_FINISH, 8'h00, 8'd1,   1'b1, EMPTY_DIGEST},  // back-to-back finish is empty again
		'{ACT_ABSORB, 8'hff, 8'd120, 1'b0, '0},            // one block then 56 bytes
		'{ACT_FINISH, 8'haa, 8'd1,   1'b0, '0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req_data;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_wdata;

	// predictor copy of the hashing state and the pinned digest
	logic [31:0] chain [0:7];
	logic [7:0]  blk [0:63];
	logic [5:0]  fill_n;
	logic [63:0] bits_done;
	logic [63:0] pin_reg [0:3];

	res_t        digest_due [$];   // digests owed by the block, oldest first
	logic [7:0]  msg_bytes [$];    // message about to be sent
	int          fail_count = 0;
	int          items_sent = 0;
	int          snd_idle = 0;     // percent of cycles the request side holds back
	int          rcv_idle = 0;     // percent of cycles the result side stalls
	int          hold_asks = 0;    // bumped to ask the result side for a long hold-off
	int          quiet_cycles = 0;

	sha256_stream_hasher_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// one 64-round compression of blk into chain
	task automatic compress_blk();
		logic [31:0] w [0:63];
		logic [31:0] v [0:7];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i - 15], 7) ^ rotr(w[i - 15], 18) ^ (w[i - 15] >> 3);
			s1 = rotr(w[i - 2], 17) ^ rotr(w[i - 2], 19) ^ (w[i - 2] >> 10);
			w[i] = w[i - 16] + s0 + w[i - 7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
			t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
			s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
			t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endtask

	task automatic restart_hash();
		for (int i = 0; i < 8; i++)
			chain[i] = SHA_IV[i];
		fill_n = '0;
		bits_done = '0;
	endtask

	// predicts one request; made is set when the request owes a digest
	task automatic hash_request(input req_t r, output bit made, output res_t d);
		int          pos;
		logic [63:0] total;
		logic [255:0] dg;
		bit          nonempty;
		made = 1'b0;
		d = '0;
		if (r.action == ACT_ABSORB) begin
			blk[fill_n] = r.data_byte;
			fill_n = fill_n + 1'b1;
			if (fill_n == '0) begin
				compress_blk();
				bits_done = bits_done + 64'd512;
			end
		end else begin
			nonempty = (fill_n != '0) || (bits_done != '0);
			total = bits_done + {55'd0, fill_n, 3'd0};
			pos = int'(fill_n);
			blk[pos[5:0]] = PAD_MARK;
			pos = pos + 1;
			// no room for the length: finish this block with zeros, length goes in the next
			if (pos > 56) begin
				while (pos < 64) begin
					blk[pos[5:0]] = '0;
					pos = pos + 1;
				end
				compress_blk();
				pos = 0;
			end
			while (pos < 56) begin
				blk[pos[5:0]] = '0;
				pos = pos + 1;
			end
			for (int i = 0; i < 8; i++)
				blk[56 + i] = total[63 - 8 * i -: 8];
			compress_blk();
			dg = {chain[0], chain[1], chain[2], chain[3], chain[4], chain[5], chain[6], chain[7]};
			d.digest_high      = dg[255:192];
			d.digest_upper_mid = dg[191:128];
			d.digest_lower_mid = dg[127:64];
			d.digest_low       = dg[63:0];
			d.pin_match = nonempty && (dg == {pin_reg[0], pin_reg[1], pin_reg[2], pin_reg[3]});
			made = 1'b1;
			restart_hash();
		end
	endtask

	// offers one request, waits for the handshake, then records what it owes
	task automatic put_req(input req_t r);
		bit   made;
		res_t d;
		if ($urandom_range(99) < snd_idle) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (req_stall);
		hash_request(r, made, d);
		if (made)
			digest_due = {digest_due, d};
		items_sent++;
	endtask

	// sends msg_bytes followed by a finish carrying a junk data byte
	task automatic send_message();
		req_t r;
		foreach (msg_bytes[i]) begin
			r.action = ACT_ABSORB;
			r.data_byte = msg_bytes[i];
			put_req(r);
		end
		r.action = ACT_FINISH;
		r.data_byte = 8'($urandom_range(255));
		put_req(r);
	endtask

	task automatic fill_msg(input int len);
		msg_bytes.delete();
		repeat (len) msg_bytes = {msg_bytes, 8'($urandom_range(255))};
	endtask

	// digest of msg_bytes; only valid while the predictor sits at the initial state
	task automatic preview_digest(output logic [255:0] dg);
		req_t r;
		bit   made;
		res_t d;
		foreach (msg_bytes[i]) begin
			r.action = ACT_ABSORB;
			r.data_byte = msg_bytes[i];
			hash_request(r, made, d);
		end
		r.action = ACT_FINISH;
		r.data_byte = '0;
		hash_request(r, made, d);
		dg = {d.digest_high, d.digest_upper_mid, d.digest_lower_mid, d.digest_low};
	endtask

	// one register write; the caller drops cfg_we after the last one
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx <= CFG_PIN_LOW)
			pin_reg[idx[1:0]] = val;
	endtask

	task automatic program_pins(input logic [255:0] v, input bit spares);
		cfg_write(CFG_PIN_HIGH, v[255:192]);
		cfg_write(CFG_PIN_UPPER_MID, v[191:128]);
		cfg_write(CFG_PIN_LOWER_MID, v[127:64]);
		cfg_write(CFG_PIN_LOW, v[63:0]);
		// junk to the unused indexes must leave the pins alone
		if (spares)
			for (int k = int'(CFG_FIRST_SPARE); k < (1 << CFG_IDX_W); k++)
				cfg_write(k[CFG_IDX_W-1:0], {$urandom, $urandom});
		cfg_we <= 1'b0;
	endtask

	// sender pauses until every owed digest is back, then lets a trailing pad finish
	task automatic settle();
		req_valid <= 1'b0;
		while (digest_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random messages until both the request and the message goals are met; lengths lean
	// short with a share on the pad boundaries and a few multi-block ones
	task automatic random_messages(input int item_goal, input int msg_goal);
		int start_items;
		int sent;
		int len;
		start_items = items_sent;
		sent = 0;
		while (items_sent - start_items < item_goal || sent < msg_goal) begin
			case ($urandom_range(9))
				0, 1, 2, 3: len = $urandom_range(10);
				4, 5: begin
					case ($urandom_range(3))
						0: len = 55;
						1: len = 56;
						2: len = 63;
						default: len = 64;
					endcase
					len = len + 64 * $urandom_range(1);
				end
				6, 7, 8: len = $urandom_range(70, 11);
				default: len = $urandom_range(200, 71);
			endcase
			fill_msg(len);
			send_message();
			sent++;
		end
	endtask

	task automatic check_field(input string tag, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, tag, want, got);
		end
	endtask

	// result side: long hold-off on request, otherwise random stalls at rcv_idle percent
	always @(posedge clk) begin : result_stall
		int hold_left;
		int hold_seen;
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			res_stall <= 1'b1;
		end else if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	// every accepted digest is matched against the oldest owed one
	always @(posedge clk) begin : digest_check
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (digest_due.size() == 0) begin
				fail_count++;
				$display("%0t ns: digest with none owed, expected none, actual %h", $time,
					res_data);
			end else begin
				want = digest_due.pop_front();
				check_field("digest_high", want.digest_high, res_data.digest_high);
				check_field("digest_upper_mid", want.digest_upper_mid,
					res_data.digest_upper_mid);
				check_field("digest_lower_mid", want.digest_lower_mid,
					res_data.digest_lower_mid);
				check_field("digest_low", want.digest_low, res_data.digest_low);
				check_field("pin_match", 64'(want.pin_match), 64'(res_data.pin_match));
			end
		end
	end

	// hang guard: any handshake or register write counts as progress
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("sha256_stream_hasher_unit regression: fail");
			$finish;
		end
	end

	initial begin
		req_t         r;
		logic [255:0] pin_val;

		req_valid <= 1'b0;
		req_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		restart_hash();
		for (int i = 0; i < 4; i++)
			pin_reg[i] = '0;
		for (int i = 0; i < 64; i++)
			blk[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed table with the pins at their reset value of zero
		snd_idle = 31;
		rcv_idle = 79;
		for (int n = 0; n < $size(DIR_ROWS); n++) begin
			for (int k = 0; k < DIR_ROWS[n].reps; k++) begin
				r.action = DIR_ROWS[n].action;
				r.data_byte = DIR_ROWS[n].data_byte + k[7:0];
				put_req(r);
				if (DIR_ROWS[n].typed)
					digest_due[digest_due.size() - 1] = DIR_ROWS[n].want;
			end
		end
		settle();

		// all-ones pins, spare indexes hit with junk, then random traffic
		program_pins('1, 1'b1);
		random_messages(25, 1);
		settle();

		// pin the digest of a two-block message: it must match, twice, the second time
		// after junk writes to the spare indexes
		fill_msg(57);
		preview_digest(pin_val);
		program_pins(pin_val, 1'b0);
		send_message();
		settle();
		program_pins(pin_val, 1'b1);
		send_message();
		settle();
		// one pin bit off: no match
		program_pins(pin_val ^ 256'd1, 1'b0);
		send_message();
		settle();
		// empty message never matches, even against its own digest
		msg_bytes.delete();
		preview_digest(pin_val);
		program_pins(pin_val, 1'b0);
		send_message();
		settle();

		// roles swapped: slow sender, eager receiver, random pins
		snd_idle = 79;
		rcv_idle = 31;
		program_pins({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom}, 1'b0);
		random_messages(25, 1);
		settle();

		// back-pressure: result side holds off while short messages keep coming, so the
		// result slot and word queue fill and the request side must stall
		snd_idle = 0;
		hold_asks <= hold_asks + 1;
		for (int m = 0; m < 20; m++) begin
			fill_msg($urandom_range(3));
			send_message();
		end
		settle();

		// no idling at all, pins back to zero
		rcv_idle = 0;
		program_pins('0, 1'b0);
		random_messages(25, 1);
		settle();

		if (fail_count == 0)
			$display("sha256_stream_hasher_unit regression: pass");
		else
			$display("sha256_stream_hasher_unit regression: fail");
		$finish;
	end

endmodule
